// ===== hw/rtl/nss_pkg.sv =====
// shared types and constants of the nucleotide segment scorer
// no dependencies
`default_nettype none

package nss_pkg;

  localparam int CHAR_W       = 8;
  localparam int LEN_W        = 16;
  localparam int WEIGHT_W     = 11;
  localparam int WT_EXT_W     = WEIGHT_W + 1;
  localparam int CNT_W        = 6;
  localparam int SEG_W        = 5;
  localparam int SCORE_W      = 27;
  localparam int CFG_IDX_W    = 2;
  localparam int MAX_SEGMENTS = 32;
  localparam int PROD_W       = 23;
  localparam int Q_DEPTH      = 2;
  localparam int Q_PTR_W      = 1;
  localparam int Q_CNT_W      = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_AT_WEIGHT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CG_WEIGHT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OTHER_WEIGHT  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FEATURE_COUNT = 2'd3;

  localparam logic [CNT_W-1:0] CNT_RESET = 6'd1;

  typedef struct packed {
    logic signed [WT_EXT_W-1:0] weight;
    logic [LEN_W-1:0]           len;
  } nss_item_t;

endpackage

`default_nettype wire

// ===== hw/rtl/nucleotide_segment_scorer_unit.sv =====
// nucleotide segment scorer top level: config registers, front end, queue, engine
// the engine takes each character through its pre and post states and stays there while segment scores are emitted
// from input to result a character passes the queue entry, the engine state registers and the output register
// the front end takes a character every cycle while the 2-entry queue has room
// synchronous active-low reset clears weights to 0, feature_count to 1, and all sums
// depends on nss_pkg, nss_front, nss_queue, nss_back
`default_nettype none

module nucleotide_segment_scorer_unit
  import nss_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [WEIGHT_W-1:0]   cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [CHAR_W-1:0]     in_base_char,
  input  wire logic [LEN_W-1:0]      in_seq_length,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [SEG_W-1:0]           out_segment_index,
  output logic signed [SCORE_W-1:0]  out_segment_score,
  output logic                       out_last_segment
);

  logic signed [WEIGHT_W-1:0] at_weight_r;
  logic signed [WEIGHT_W-1:0] cg_weight_r;
  logic signed [WEIGHT_W-1:0] other_weight_r;
  logic [CNT_W-1:0]           feature_count_r;

  logic      q_push;
  logic      q_full;
  logic      q_pop;
  logic      q_not_empty;
  nss_item_t q_in_item;
  nss_item_t q_head_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      at_weight_r     <= '0;
      cg_weight_r     <= '0;
      other_weight_r  <= '0;
      feature_count_r <= CNT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_AT_WEIGHT:     at_weight_r     <= cfg_data;
        CFG_CG_WEIGHT:     cg_weight_r     <= cfg_data;
        CFG_OTHER_WEIGHT:  other_weight_r  <= cfg_data;
        CFG_FEATURE_COUNT: feature_count_r <= cfg_data[CNT_W-1:0];
        default:           feature_count_r <= feature_count_r;
      endcase
    end
  end

  nss_front u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_base_char  (in_base_char),
    .in_seq_length (in_seq_length),
    .at_weight     (at_weight_r),
    .cg_weight     (cg_weight_r),
    .other_weight  (other_weight_r),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_item        (q_in_item)
  );

  nss_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_item (q_head_item)
  );

  nss_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .feature_count     (feature_count_r),
    .q_not_empty       (q_not_empty),
    .q_item            (q_head_item),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_segment_index (out_segment_index),
    .out_segment_score (out_segment_score),
    .out_last_segment  (out_last_segment)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/nss_front.sv =====
// front end: accepts characters and maps each one to its signed weight
// depends on nss_pkg
`default_nettype none

module nss_front
  import nss_pkg::*;
(
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [CHAR_W-1:0]          in_base_char,
  input  wire logic [LEN_W-1:0]           in_seq_length,
  input  wire logic signed [WEIGHT_W-1:0] at_weight,
  input  wire logic signed [WEIGHT_W-1:0] cg_weight,
  input  wire logic signed [WEIGHT_W-1:0] other_weight,
  input  wire logic                       q_full,
  output logic                            q_push,
  output nss_item_t                       q_item
);

  logic signed [WT_EXT_W-1:0] at_ext;
  logic signed [WT_EXT_W-1:0] cg_ext;
  logic signed [WT_EXT_W-1:0] other_ext;
  logic signed [WT_EXT_W-1:0] weight;

  assign at_ext    = {at_weight[WEIGHT_W-1], at_weight};
  assign cg_ext    = {cg_weight[WEIGHT_W-1], cg_weight};
  assign other_ext = {other_weight[WEIGHT_W-1], other_weight};

  always_comb begin
    case (in_base_char)
      "A", "a":           weight = at_ext;
      "T", "t", "U", "u": weight = -at_ext;
      "G", "g":           weight = cg_ext;
      "C", "c":           weight = -cg_ext;
      "r", "y", "s", "w", "k", "m", "b", "d", "h", "v", "n",
      "R", "Y", "S", "W", "K", "M", "B", "D", "H", "V", "N":
                          weight = other_ext;
      default:            weight = '0;
    endcase
  end

  assign in_ready      = !q_full;
  assign q_push        = in_valid && !q_full;
  assign q_item.weight = weight;
  assign q_item.len    = (in_seq_length == '0) ? LEN_W'(1) : in_seq_length;

endmodule

`default_nettype wire

// ===== hw/rtl/nss_queue.sv =====
// short queue between the front end and the segment engine
// depends on nss_pkg
`default_nettype none

module nss_queue
  import nss_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire nss_item_t push_item,
  output logic           full,
  input  wire logic      pop,
  output logic           not_empty,
  output nss_item_t      head_item
);

  nss_item_t            mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r;
  logic [Q_PTR_W-1:0]   rd_ptr_r;
  logic [Q_CNT_W-1:0]   count_r;

  assign full      = (count_r == Q_CNT_W'(Q_DEPTH));
  assign not_empty = (count_r != '0);
  assign head_item = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + Q_PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + Q_CNT_W'(1);
        2'b01:   count_r <= count_r - Q_CNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/nss_back.sv =====
// segment engine: sums weights per segment and emits segment scores
// depends on nss_pkg
`default_nettype none

module nss_back
  import nss_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic [CNT_W-1:0]    feature_count,
  input  wire logic                q_not_empty,
  input  wire nss_item_t           q_item,
  output logic                     q_pop,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [SEG_W-1:0]         out_segment_index,
  output logic signed [SCORE_W-1:0] out_segment_score,
  output logic                     out_last_segment
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_PRE,
    S_POST
  } state_t;

  state_t                      state_r, state_nxt;
  logic [LEN_W-1:0]            pos_r, pos_nxt;
  logic [SEG_W-1:0]            seg_r, seg_nxt;
  logic signed [SCORE_W-1:0]   score_r, score_nxt;
  logic signed [WT_EXT_W-1:0]  wt_r, wt_nxt;
  logic [LEN_W-1:0]            len_r, len_nxt;
  logic                        ov_r, ov_nxt;
  logic [SEG_W-1:0]            oidx_r, oidx_nxt;
  logic signed [SCORE_W-1:0]   oscore_r, oscore_nxt;
  logic                        olast_r, olast_nxt;

  logic [CNT_W-1:0]            cnt;
  logic [CNT_W-1:0]            seg_p1;
  logic [PROD_W-1:0]           end_prod;
  logic [PROD_W-1:0]           pos_prod;
  logic                        seg_done;
  logic                        seg_last;
  logic                        out_free;
  logic                        take;
  logic signed [SCORE_W:0]     sum;
  logic signed [SCORE_W-1:0]   sum_sat;

  always_comb begin
    if (feature_count == '0) begin
      cnt = CNT_W'(1);
    end else if (feature_count > CNT_W'(MAX_SEGMENTS)) begin
      cnt = CNT_W'(MAX_SEGMENTS);
    end else begin
      cnt = feature_count;
    end
  end

  // segment seg ends at or before pos when len*(seg+1) < (pos+1)*cnt
  assign seg_p1   = {1'b0, seg_r} + CNT_W'(1);
  assign end_prod = PROD_W'(len_r) * PROD_W'(seg_p1);
  assign pos_prod = PROD_W'({1'b0, pos_r} + 17'd1) * PROD_W'(cnt);
  assign seg_done = (end_prod < pos_prod) && ({1'b0, seg_r} < cnt);
  assign seg_last = (seg_p1 == cnt);
  assign out_free = !ov_r || out_ready;

  assign sum = {score_r[SCORE_W-1], score_r}
             + {{(SCORE_W + 1 - WT_EXT_W){wt_r[WT_EXT_W-1]}}, wt_r};

  always_comb begin
    if (sum[SCORE_W] != sum[SCORE_W-1]) begin
      sum_sat = sum[SCORE_W] ? {1'b1, {(SCORE_W-1){1'b0}}} : {1'b0, {(SCORE_W-1){1'b1}}};
    end else begin
      sum_sat = sum[SCORE_W-1:0];
    end
  end

  always_comb begin
    state_nxt  = state_r;
    pos_nxt    = pos_r;
    seg_nxt    = seg_r;
    score_nxt  = score_r;
    wt_nxt     = wt_r;
    len_nxt    = len_r;
    ov_nxt     = ov_r && !out_ready;
    oidx_nxt   = oidx_r;
    oscore_nxt = oscore_r;
    olast_nxt  = olast_r;
    take       = 1'b0;

    case (state_r)
      S_IDLE: begin
        take = q_not_empty;
      end
      S_PRE: begin
        if (seg_done) begin
          if (out_free) begin
            ov_nxt     = 1'b1;
            oidx_nxt   = seg_r;
            oscore_nxt = score_r;
            olast_nxt  = seg_last;
            score_nxt  = '0;
            seg_nxt    = seg_r + SEG_W'(1);
          end
        end else begin
          score_nxt = sum_sat;
          pos_nxt   = pos_r + LEN_W'(1);
          state_nxt = S_POST;
        end
      end
      S_POST: begin
        if (seg_done) begin
          if (out_free) begin
            ov_nxt     = 1'b1;
            oidx_nxt   = seg_r;
            oscore_nxt = score_r;
            olast_nxt  = seg_last;
            score_nxt  = '0;
            seg_nxt    = seg_r + SEG_W'(1);
            if (seg_last) begin
              pos_nxt   = '0;
              seg_nxt   = '0;
              state_nxt = S_IDLE;
              take      = q_not_empty;
            end
          end
        end else begin
          state_nxt = S_IDLE;
          take      = q_not_empty;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // new character: drop a stale sequence before starting on it
    if (take) begin
      wt_nxt    = q_item.weight;
      len_nxt   = q_item.len;
      state_nxt = S_PRE;
      if ((pos_nxt >= q_item.len) || ({1'b0, seg_nxt} >= cnt)) begin
        pos_nxt   = '0;
        seg_nxt   = '0;
        score_nxt = '0;
      end
    end
  end

  assign q_pop = take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pos_r   <= '0;
      seg_r   <= '0;
      score_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      seg_r   <= seg_nxt;
      score_r <= score_nxt;
      ov_r    <= ov_nxt;
    end
    wt_r     <= wt_nxt;
    len_r    <= len_nxt;
    oidx_r   <= oidx_nxt;
    oscore_r <= oscore_nxt;
    olast_r  <= olast_nxt;
  end

  assign out_valid         = ov_r;
  assign out_segment_index = oidx_r;
  assign out_segment_score = oscore_r;
  assign out_last_segment  = olast_r;

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// testbench for nucleotide_segment_scorer_unit: streams characters, checks segment scores
// against an in-bench tracker of per-segment weight sums
// depends on nss_pkg and the nucleotide_segment_scorer_unit rtl
`timescale 1ns / 100ps

module tb;
  import nss_pkg::*;

  localparam int STALL_LIMIT      = 2000;
  localparam int SETTLE_CYCLES    = 16;
  localparam int RANDOM_PER_PHASE = 40;
  localparam int MAX_REPORTS      = 10;
  localparam longint SCORE_HI     = (longint'(1) << (SCORE_W - 1)) - 1;
  localparam longint SCORE_LO     = -(longint'(1) << (SCORE_W - 1));

  typedef struct {
    logic [CHAR_W-1:0] ch;
    logic [LEN_W-1:0]  len;
  } base_item_t;

  typedef struct {
    logic [SEG_W-1:0]          seg_idx;
    logic signed [SCORE_W-1:0] score;
    logic                      last;
  } segment_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index = '0;
  logic [WEIGHT_W-1:0]       cfg_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [CHAR_W-1:0]         in_base_char = '0;
  logic [LEN_W-1:0]          in_seq_length = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [SEG_W-1:0]          out_segment_index;
  logic signed [SCORE_W-1:0] out_segment_score;
  logic                      out_last_segment;

  base_item_t pending_bases[$];
  segment_t   scores_due[$];
  base_item_t queued_item;
  base_item_t taken_item;
  segment_t   want;

  // tracker copy of the registers and sequence state
  logic signed [WEIGHT_W-1:0] at_w = '0;
  logic signed [WEIGHT_W-1:0] cg_w = '0;
  logic signed [WEIGHT_W-1:0] other_w = '0;
  logic [CNT_W-1:0]           fcount = CNT_RESET;
  int                         char_pos = 0;
  int                         seg_no = 0;
  longint                     open_sum = 0;

  int    send_idle_pct = 0;
  int    recv_idle_pct = 0;
  int    mismatch_count = 0;
  int    idle_cycles = 0;
  string nucleo_chars = "ACGTUacgtu";
  string ambig_chars = "ryswkmbdhvnRYSWKMBDHVN";

  always #2 clk = ~clk;

  nucleotide_segment_scorer_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_base_char      (in_base_char),
    .in_seq_length     (in_seq_length),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_segment_index (out_segment_index),
    .out_segment_score (out_segment_score),
    .out_last_segment  (out_last_segment)
  );

  function automatic int base_weight(input logic [CHAR_W-1:0] ch);
    case (ch)
      "A", "a": return int'(at_w);
      "T", "t", "U", "u": return -int'(at_w);
      "G", "g": return int'(cg_w);
      "C", "c": return -int'(cg_w);
      "r", "y", "s", "w", "k", "m", "b", "d", "h", "v", "n",
      "R", "Y", "S", "W", "K", "M", "B", "D", "H", "V", "N": return int'(other_w);
      default: return 0;
    endcase
  endfunction

  // emit every segment whose end lies at or before upto
  task automatic close_segments(input int upto, input int len, input int cnt,
                                inout bit done);
    segment_t s;
    while (!done && seg_no < cnt && (longint'(len) * (seg_no + 1)) / cnt <= upto) begin
      s.seg_idx = seg_no[SEG_W-1:0];
      s.score = open_sum[SCORE_W-1:0];
      s.last = (seg_no + 1 == cnt);
      scores_due = {scores_due, s};
      open_sum = 0;
      seg_no++;
      if (s.last) done = 1'b1;
    end
  endtask

  task automatic score_base(input base_item_t it);
    int     cnt;
    int     len;
    longint sum;
    bit     done;
    cnt = (fcount == 0) ? 1 : ((fcount > MAX_SEGMENTS) ? MAX_SEGMENTS : int'(fcount));
    len = (it.len == 0) ? 1 : int'(it.len);
    done = 1'b0;
    // stale sequence state is dropped
    if (char_pos >= len || seg_no >= cnt) begin
      char_pos = 0;
      seg_no = 0;
      open_sum = 0;
    end
    close_segments(char_pos, len, cnt, done);
    sum = open_sum + base_weight(it.ch);
    if (sum > SCORE_HI) sum = SCORE_HI;
    if (sum < SCORE_LO) sum = SCORE_LO;
    open_sum = sum;
    char_pos++;
    close_segments(char_pos, len, cnt, done);
    if (done) begin
      char_pos = 0;
      seg_no = 0;
      open_sum = 0;
    end
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        taken_item.ch = in_base_char;
        taken_item.len = in_seq_length;
        score_base(taken_item);
      end
      if (!in_valid || in_ready) begin
        if (pending_bases.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          queued_item = pending_bases.pop_front();
          in_valid <= 1'b1;
          in_base_char <= queued_item.ch;
          in_seq_length <= queued_item.len;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (scores_due.size() == 0) begin
        if (mismatch_count < MAX_REPORTS)
          $display("unexpected segment result: index %0d score %0d last %0b",
                   out_segment_index, out_segment_score, out_last_segment);
        mismatch_count++;
      end else begin
        want = scores_due.pop_front();
        if (out_segment_index !== want.seg_idx || out_segment_score !== want.score ||
            out_last_segment !== want.last) begin
          if (mismatch_count < MAX_REPORTS)
            $display("segment mismatch: expected index %0d score %0d last %0b, got %0d %0d %0b",
                     want.seg_idx, want.score, want.last,
                     out_segment_index, out_segment_score, out_last_segment);
          mismatch_count++;
        end
      end
    end
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == STALL_LIMIT) begin
      $display("FAIL nucleotide_segment_scorer_unit");
      $finish;
    end
  end

  task automatic push_item(input logic [CHAR_W-1:0] ch, input logic [LEN_W-1:0] len);
    base_item_t it;
    it.ch = ch;
    it.len = len;
    pending_bases = {pending_bases, it};
  endtask

  task automatic push_text(input logic [LEN_W-1:0] len, input string text);
    for (int i = 0; i < text.len(); i++) push_item(text[i], len);
  endtask

  function automatic logic [CHAR_W-1:0] random_base();
    int pick;
    pick = $urandom_range(3);
    if (pick < 2) return nucleo_chars[$urandom_range(nucleo_chars.len() - 1)];
    if (pick == 2) return ambig_chars[$urandom_range(ambig_chars.len() - 1)];
    return CHAR_W'($urandom_range(255));
  endfunction

  task automatic wait_idle();
    while (pending_bases.size() != 0 || in_valid || scores_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[WEIGHT_W-1:0];
    case (idx)
      CFG_AT_WEIGHT:     at_w = value[WEIGHT_W-1:0];
      CFG_CG_WEIGHT:     cg_w = value[WEIGHT_W-1:0];
      CFG_OTHER_WEIGHT:  other_w = value[WEIGHT_W-1:0];
      CFG_FEATURE_COUNT: fcount = value[CNT_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic program_weights(input int at, input int cg, input int other, input int count);
    wait_idle();
    cfg_write(CFG_AT_WEIGHT, at);
    cfg_write(CFG_CG_WEIGHT, cg);
    cfg_write(CFG_OTHER_WEIGHT, other);
    cfg_write(CFG_FEATURE_COUNT, count);
  endtask

  function automatic int random_weight();
    return int'($urandom_range(2047)) - 1024;
  endfunction

  // mostly whole sequences, some cut short with arbitrary lengths
  task automatic random_phase();
    int added;
    int len;
    int n;
    added = 0;
    while (added < RANDOM_PER_PHASE) begin
      if ($urandom_range(4) != 0) begin
        len = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
        n = len;
      end else begin
        len = $urandom_range(16'hFFFF);
        n = $urandom_range(1, 3);
      end
      repeat (n) push_item(random_base(), len[LEN_W-1:0]);
      added += n;
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 27;
    recv_idle_pct = 75;

    program_weights(1023, -1024, -1, 3);
    push_text(16'd0, "A");
    push_text(16'd12, "ACGTUacgtuRn");
    push_item(8'hFF, 16'hFFFF);
    push_item(8'h00, 16'hFFFF);
    push_text(16'd2, "Bd");
    push_text(16'd4, "sWhV");

    program_weights(-1024, 1023, -1024, MAX_SEGMENTS);
    random_phase();

    send_idle_pct = 75;
    recv_idle_pct = 27;
    program_weights(1023, -1024, 1023, 1);
    random_phase();
    program_weights(random_weight(), random_weight(), random_weight(), 0);
    random_phase();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    program_weights(random_weight(), random_weight(), random_weight(), 63);
    random_phase();
    program_weights(random_weight(), random_weight(), random_weight(), $urandom_range(2, 31));
    random_phase();

    wait_idle();
    if (mismatch_count == 0) begin
      $display("PASS nucleotide_segment_scorer_unit");
    end else begin
      $display("FAIL nucleotide_segment_scorer_unit");
    end
    $finish;
  end

endmodule

// ===== nucleotide_segment_scorer_unit.f =====
hw/rtl/nss_pkg.sv
hw/rtl/nss_front.sv
hw/rtl/nss_queue.sv
hw/rtl/nss_back.sv
hw/rtl/nucleotide_segment_scorer_unit.sv
tb/sv/tb.sv
